[design/tdd_pkg.sv]
`default_nettype none

package tdd_pkg;

    localparam int TDD_SLOTS           = 8;
    localparam int TDD_SLOT_W          = 3;
    localparam logic [31:0] TDD_IDLE_WINDOW_RST = 32'd10;

    // commands
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_KILL = 2'd2;

    // task kinds
    localparam logic [1:0] K_NONE   = 2'd0;
    localparam logic [1:0] K_IDLE   = 2'd1;
    localparam logic [1:0] K_ONCE   = 2'd2;
    localparam logic [1:0] K_CYCLIC = 2'd3;

    // result kinds
    localparam logic [1:0] RES_DISPATCH = 2'd0;
    localparam logic [1:0] RES_TICK_END = 2'd1;
    localparam logic [1:0] RES_ADD      = 2'd2;
    localparam logic [1:0] RES_KILL     = 2'd3;

    typedef enum logic [2:0] {
        ST_READY,
        ST_TIMED,
        ST_IDLE_PASS,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] code;
        logic [31:0] period;
        logic [31:0] due;
    } slot_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [31:0]           now_ms;
        logic [1:0]            task_kind;
        logic [15:0]           task_code;
        logic [31:0]           interval_ms;
        logic [TDD_SLOT_W-1:0] slot_index;
    } req_t;

endpackage

`default_nettype wire

[design/tdd_cell.sv]
`default_nettype none

// One slot of the ring; loads its neighbor's contents on every shift.
module tdd_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire tdd_pkg::slot_t d,
    output tdd_pkg::slot_t     q
);
    import tdd_pkg::*;

    slot_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[design/tdd_step.sv]
`default_nettype none

// Evaluates the slot at the head of the ring for the current pass.
module tdd_step #(
    parameter int PW = 3
) (
    input  wire tdd_pkg::state_t mode,
    input  wire tdd_pkg::slot_t  head,
    input  wire logic [PW-1:0]   pos,
    input  wire tdd_pkg::req_t   req,
    input  wire logic [31:0]     horizon,
    input  wire logic            placed,
    output tdd_pkg::slot_t       head_next,
    output logic                 emit,
    output logic                 block,
    output logic                 take
);
    import tdd_pkg::*;

    localparam int CW = (PW > TDD_SLOT_W) ? PW : TDD_SLOT_W;

    logic        timed;
    logic        due_now;
    logic [31:0] resched;

    assign timed   = (head.kind == K_ONCE) || (head.kind == K_CYCLIC);
    assign due_now = head.due <= req.now_ms;
    assign resched = req.now_ms + head.period;

    always_comb
    begin
        head_next = head;
        emit      = 1'b0;
        block     = 1'b0;
        take      = 1'b0;
        case (mode)
            ST_TIMED:
            begin
                if (timed && due_now)
                begin
                    emit = head.code != 16'd0;
                    if (head.kind == K_ONCE)
                    begin
                        head_next = '0;
                    end
                    else
                    begin
                        head_next.due = resched;
                    end
                end
                block = timed && (head_next.due <= horizon);
            end
            ST_IDLE_PASS:
            begin
                emit = (head.kind == K_IDLE) && (head.code != 16'd0);
            end
            ST_UPDATE:
            begin
                if (req.cmd == CMD_ADD && !placed && head.kind == K_NONE
                    && req.task_kind != K_NONE)
                begin
                    take             = 1'b1;
                    head_next.kind   = req.task_kind;
                    head_next.code   = req.task_code;
                    head_next.period = (req.task_kind == K_CYCLIC) ? req.interval_ms : 32'd0;
                    head_next.due    = (req.task_kind == K_ONCE)
                                       ? req.now_ms + req.interval_ms : 32'd0;
                end
                else if (req.cmd == CMD_KILL && CW'(req.slot_index) == CW'(pos))
                begin
                    head_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

[design/timed_task_dispatcher.sv]
// Sequence from acceptance to closing result: a tick runs a timed pass and,
//   unless a timed task blocks it, an idle pass; add and kill run one update
//   pass. A dispatch or the closing result waiting on out_ready stalls it.
// No overlap between transactions: a new one is accepted only in the ready state.
// A ring of SLOTS cells rotates once per pass.
// Reset (async, rst_n low) clears every slot and sets idle_window to 10.
`default_nettype none

module timed_task_dispatcher #(
    parameter int SLOTS = tdd_pkg::TDD_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] now_ms,
    input  wire logic [1:0]  task_kind,
    input  wire logic [15:0] task_code,
    input  wire logic [31:0] interval_ms,
    input  wire logic [2:0]  slot_index,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [2:0]       slot,
    output logic [15:0]      task_code_res,
    output logic             ok,
    output logic             was_idle,
    output logic             last
);
    import tdd_pkg::*;

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t      state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;      // slot currently at the ring head
    logic        idle_reg, idle_next;      // no timed task blocks idle dispatch
    logic        placed_reg, placed_next;  // add found a free slot
    logic [PW-1:0] add_slot_reg, add_slot_next;
    logic [31:0] idle_window_reg;
    req_t        req_reg;
    logic [31:0] horizon_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  slot_reg, slot_next;
    logic [15:0] code_reg, code_next;
    logic        ok_reg, ok_next;
    logic        was_idle_reg, was_idle_next;
    logic        last_reg, last_next;
    logic        out_load;
    logic        out_free;

    // ------------------------------------------------------------------
    // Ring of slot cells: cell 0 is the head, the last cell takes the
    // updated head. After SLOTS shifts every slot is home again.
    // ------------------------------------------------------------------
    slot_t cell_q [SLOTS];
    slot_t head_next;
    logic  shift;
    logic  emit, block, take;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_ring
        slot_t cell_d;
        if (i == SLOTS - 1)
        begin : g_tail
            assign cell_d = head_next;
        end
        else
        begin : g_mid
            assign cell_d = cell_q[i+1];
        end
        tdd_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (cell_d),
            .q     (cell_q[i])
        );
    end

    tdd_step #(.PW(PW)) u_step (
        .mode      (state_reg),
        .head      (cell_q[0]),
        .pos       (cnt_reg),
        .req       (req_reg),
        .horizon   (horizon_reg),
        .placed    (placed_reg),
        .head_next (head_next),
        .emit      (emit),
        .block     (block),
        .take      (take)
    );

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic at_end;
    assign at_end   = cnt_reg == PW'(SLOTS - 1);
    assign in_ready = state_reg == ST_READY;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idle_next     = idle_reg;
        placed_next   = placed_reg;
        add_slot_next = add_slot_reg;
        shift         = 1'b0;
        out_load      = 1'b0;
        kind_next     = RES_DISPATCH;
        slot_next     = TDD_SLOT_W'(cnt_reg);
        code_next     = cell_q[0].code;
        ok_next       = 1'b0;
        was_idle_next = 1'b0;
        last_next     = 1'b0;
        case (state_reg)
            ST_READY:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    if (cmd == CMD_TICK)
                    begin
                        state_next = ST_TIMED;
                        idle_next  = 1'b1;
                    end
                    else if (cmd == CMD_ADD || cmd == CMD_KILL)
                    begin
                        state_next  = ST_UPDATE;
                        placed_next = 1'b0;
                    end
                end
            end
            ST_TIMED, ST_IDLE_PASS:
            begin
                // stall the ring while a dispatch cannot be handed over
                if (!emit || out_free)
                begin
                    shift    = 1'b1;
                    out_load = emit;
                    if (block)
                    begin
                        idle_next = 1'b0;
                    end
                    if (at_end)
                    begin
                        cnt_next = '0;
                        if (state_reg == ST_TIMED && idle_reg && !block)
                        begin
                            state_next = ST_IDLE_PASS;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_UPDATE:
            begin
                shift = 1'b1;
                if (take)
                begin
                    placed_next   = 1'b1;
                    add_slot_next = cnt_reg;
                end
                if (at_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                code_next = 16'd0;
                last_next = 1'b1;
                case (req_reg.cmd)
                    CMD_TICK:
                    begin
                        kind_next     = RES_TICK_END;
                        slot_next     = '0;
                        was_idle_next = idle_reg;
                    end
                    CMD_ADD:
                    begin
                        kind_next = RES_ADD;
                        slot_next = placed_reg ? TDD_SLOT_W'(add_slot_reg) : '0;
                        ok_next   = placed_reg;
                    end
                    default:
                    begin
                        kind_next = RES_KILL;
                        slot_next = req_reg.slot_index;
                    end
                endcase
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_READY;
            cnt_reg         <= '0;
            idle_reg        <= 1'b0;
            placed_reg      <= 1'b0;
            add_slot_reg    <= '0;
            idle_window_reg <= TDD_IDLE_WINDOW_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idle_reg     <= idle_next;
            placed_reg   <= placed_next;
            add_slot_reg <= add_slot_next;
            if (cfg_we)
            begin
                idle_window_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.cmd         <= cmd;
            req_reg.now_ms      <= now_ms;
            req_reg.task_kind   <= task_kind;
            req_reg.task_code   <= task_code;
            req_reg.interval_ms <= interval_ms;
            req_reg.slot_index  <= slot_index;
            horizon_reg         <= now_ms + idle_window_reg;
        end
        if (out_load)
        begin
            kind_reg     <= kind_next;
            slot_reg     <= slot_next;
            code_reg     <= code_next;
            ok_reg       <= ok_next;
            was_idle_reg <= was_idle_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign slot          = slot_reg;
    assign task_code_res = code_reg;
    assign ok            = ok_reg;
    assign was_idle      = was_idle_reg;
    assign last          = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READY) |-> (cnt_reg == '0))
        else $error("ring not aligned while ready");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !out_load)
        else $error("held result overwritten");

    a_last_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |-> (state_reg == ST_DONE))
        else $error("closing result outside done state");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (cmd == CMD_TICK || cmd == CMD_ADD || cmd == CMD_KILL))
        |=> (state_reg != ST_READY))
        else $error("accepted command not started");

endmodule

`default_nettype wire

[dv/timed_task_dispatcher_tb.sv]
`timescale 1ns / 100ps

module timed_task_dispatcher_tb;

    import tdd_pkg::*;

    localparam int         SLOTS         = TDD_SLOTS;
    // a tick with an idle pass walks the ring twice; leave ample margin
    localparam int         SETTLE_CYCLES = 4 * SLOTS + 8;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         MAX_WAIT      = 17;
    localparam int         PHASE_ITEMS   = 80;
    // command code the block ignores (no result, no state change)
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    // one scheduler event as it appears on the output channel
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [15:0] code;
        logic        ok;
        logic        was_idle;
        logic        last;
    } sched_event_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [1:0]  task_kind;
    logic [15:0] task_code;
    logic [31:0] interval_ms;
    logic [2:0]  slot_index;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  res_kind;
    logic [2:0]  res_slot;
    logic [15:0] res_code;
    logic        res_ok;
    logic        res_was_idle;
    logic        res_last;

    timed_task_dispatcher uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .now_ms       (now_ms),
        .task_kind    (task_kind),
        .task_code    (task_code),
        .interval_ms  (interval_ms),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (res_kind),
        .slot         (res_slot),
        .task_code_res(res_code),
        .ok           (res_ok),
        .was_idle     (res_was_idle),
        .last         (res_last)
    );

    // ------------------------------------------------------------------
    // Mirror of the task table and the idle look-ahead register
    // ------------------------------------------------------------------
    logic [1:0]  tbl_kind   [SLOTS];
    logic [15:0] tbl_code   [SLOTS];
    logic [31:0] tbl_period [SLOTS];
    logic [31:0] tbl_due    [SLOTS];
    logic [31:0] look_ahead_ms;

    req_t         request_backlog [$];   // requests not yet driven
    sched_event_t awaited_events  [$];   // events the block still owes us
    req_t         next_req;

    int          requests_queued;
    int          requests_taken;
    int          fail_count;
    int          cycle_count;
    bit          in_accepted;
    bit          out_accepted;
    int          send_wait;
    int          recv_wait;
    bit          send_calm;
    bit          recv_calm;
    logic [31:0] sim_ms;                 // running time base for random traffic

    always #5 clk = ~clk;

    function void wipe_slot(input int s);
        tbl_kind[s]   = K_NONE;
        tbl_code[s]   = '0;
        tbl_period[s] = '0;
        tbl_due[s]    = '0;
    endfunction

    function void note_event(input logic [1:0] k, input logic [2:0] s, input logic [15:0] c,
                             input logic ok_bit, input logic idle_bit, input logic last_bit);
        sched_event_t ev;
        ev.kind     = k;
        ev.slot     = s;
        ev.code     = c;
        ev.ok       = ok_bit;
        ev.was_idle = idle_bit;
        ev.last     = last_bit;
        awaited_events.push_back(ev);
    endfunction

    // Applies one accepted request to the mirror and queues the events it causes.
    function void run_scheduler(input req_t r);
        logic [31:0] horizon;
        bit          run_idle;
        bit          placed;
        horizon  = r.now_ms + look_ahead_ms;   // wraps at 32 bits
        run_idle = 1'b1;
        placed   = 1'b0;
        case (r.cmd)
            CMD_TICK:
            begin
                // timed pass: due once-tasks fire and leave, cyclic ones re-arm
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (tbl_kind[s] == K_ONCE || tbl_kind[s] == K_CYCLIC)
                    begin
                        if (tbl_due[s] <= r.now_ms)
                        begin
                            if (tbl_code[s] != 0)
                                note_event(RES_DISPATCH, 3'(s), tbl_code[s],
                                           1'b0, 1'b0, 1'b0);
                            if (tbl_kind[s] == K_ONCE)
                                wipe_slot(s);
                            else
                                tbl_due[s] = r.now_ms + tbl_period[s];
                        end
                        // a cleared once-slot has due 0 and still blocks the idle pass
                        if (tbl_due[s] <= horizon)
                            run_idle = 1'b0;
                    end
                end
                if (run_idle)
                begin
                    for (int s = 0; s < SLOTS; s++)
                        if (tbl_kind[s] == K_IDLE && tbl_code[s] != 0)
                            note_event(RES_DISPATCH, 3'(s), tbl_code[s], 1'b0, 1'b0, 1'b0);
                end
                note_event(RES_TICK_END, '0, '0, 1'b0, run_idle, 1'b1);
            end
            CMD_ADD:
            begin
                if (r.task_kind != K_NONE)
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!placed && tbl_kind[s] == K_NONE)
                        begin
                            tbl_kind[s]   = r.task_kind;
                            tbl_code[s]   = r.task_code;
                            tbl_period[s] = (r.task_kind == K_CYCLIC) ? r.interval_ms : '0;
                            tbl_due[s]    = (r.task_kind == K_ONCE) ? r.now_ms + r.interval_ms
                                                                    : '0;
                            placed        = 1'b1;
                            note_event(RES_ADD, 3'(s), '0, 1'b1, 1'b0, 1'b1);
                        end
                    end
                end
                // kind none or full table
                if (!placed)
                    note_event(RES_ADD, '0, '0, 1'b0, 1'b0, 1'b1);
            end
            CMD_KILL:
            begin
                if (r.slot_index < SLOTS)
                    wipe_slot(int'(r.slot_index));
                note_event(RES_KILL, r.slot_index, '0, 1'b0, 1'b0, 1'b1);
            end
            default: ;   // unused command: silently dropped
        endcase
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function req_t make_request(input logic [1:0] c, input logic [31:0] t,
                                input logic [1:0] k, input logic [15:0] code,
                                input logic [31:0] iv, input logic [2:0] idx);
        req_t r;
        r.cmd         = c;
        r.now_ms      = t;
        r.task_kind   = k;
        r.task_code   = code;
        r.interval_ms = iv;
        r.slot_index  = idx;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on input transactions, checks output transactions.
    // Also mirrors config writes and enforces the cycle limit.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_event_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                if (cfg_we)
                    look_ahead_ms = cfg_data;
                in_accepted  = in_valid && in_ready;
                out_accepted = out_valid && out_ready;
                if (in_accepted)
                begin
                    requests_taken++;
                    run_scheduler(make_request(cmd, now_ms, task_kind, task_code,
                                               interval_ms, slot_index));
                end
                if (out_accepted)
                begin
                    if (awaited_events.size() == 0)
                    begin
                        $error("unexpected result: kind %0d slot %0d code 0x%0h",
                               res_kind, res_slot, res_code);
                        fail_count++;
                    end
                    else
                    begin
                        want = awaited_events.pop_front();
                        check_field("kind", 32'(want.kind), 32'(res_kind));
                        check_field("slot", 32'(want.slot), 32'(res_slot));
                        check_field("task_code_res", 32'(want.code), 32'(res_code));
                        check_field("ok", 32'(want.ok), 32'(res_ok));
                        check_field("was_idle", 32'(want.was_idle), 32'(res_was_idle));
                        check_field("last", 32'(want.last), 32'(res_last));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: pops the backlog at the falling edge. After each transaction
    // it may idle for a random gap bounded by MAX_WAIT; calm stretches drop the gaps entirely.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!in_valid || in_accepted)
        begin
            if (send_wait > 0)
            begin
                in_valid <= 1'b0;
                send_wait--;
            end
            else if (request_backlog.size() != 0)
            begin
                next_req = request_backlog.pop_front();
                cmd         <= next_req.cmd;
                now_ms      <= next_req.now_ms;
                task_kind   <= next_req.task_kind;
                task_code   <= next_req.task_code;
                interval_ms <= next_req.interval_ms;
                slot_index  <= next_req.slot_index;
                in_valid    <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    send_calm = !send_calm;
                send_wait = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: may stall after each output transaction, plus stray drops of ready outside calm stretches.
    always @(negedge clk)
    begin
        if (out_accepted)
        begin
            if ($urandom_range(0, 15) == 0)
                recv_calm = !recv_calm;
            recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (recv_wait > 0)
        begin
            out_ready <= 1'b0;
            recv_wait--;
        end
        else if (!recv_calm && $urandom_range(0, 9) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; fields a command ignores carry random noise
    // ------------------------------------------------------------------
    task queue_request(input req_t r);
        request_backlog.push_back(r);
        requests_queued++;
    endtask

    task queue_tick(input logic [31:0] t);
        queue_request(make_request(CMD_TICK, t, 2'($urandom()), 16'($urandom()),
                                   $urandom(), 3'($urandom())));
    endtask

    task queue_add(input logic [31:0] t, input logic [1:0] k, input logic [15:0] code,
                   input logic [31:0] iv);
        queue_request(make_request(CMD_ADD, t, k, code, iv, 3'($urandom())));
    endtask

    task queue_kill(input logic [2:0] idx);
        queue_request(make_request(CMD_KILL, $urandom(), 2'($urandom()), 16'($urandom()),
                                   $urandom(), idx));
    endtask

    // Sender holds off until every transaction is taken and every event is back,
    // then lets the block settle (an ignored command owes no event).
    task wait_quiet();
        do
            @(negedge clk);
        while (requests_taken != requests_queued || awaited_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_window(input logic [31:0] v);
        @(negedge clk);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly a well-formed timeline: time moves forward in small steps,
    // short intervals so tasks actually come due; a few far jumps and junk.
    task queue_random_requests(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                sim_ms = sim_ms + $urandom_range(0, 12);
                queue_tick(sim_ms);
            end
            else if (pick < 78)
                queue_add(sim_ms,
                          ($urandom_range(0, 15) == 0) ? K_NONE : 2'($urandom_range(1, 3)),
                          ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom()),
                          ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 40));
            else if (pick < 95)
                queue_kill(3'($urandom_range(0, SLOTS - 1)));
            else if (pick < 98)
                queue_request(make_request(CMD_UNUSED, $urandom(), 2'($urandom()),
                                           16'($urandom()), $urandom(), 3'($urandom())));
            else
                queue_tick($urandom());
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cmd         = CMD_TICK;
        now_ms      = '0;
        task_kind   = K_NONE;
        task_code   = '0;
        interval_ms = '0;
        slot_index  = '0;
        out_ready   = 1'b0;

        look_ahead_ms = TDD_IDLE_WINDOW_RST;
        for (int s = 0; s < SLOTS; s++)
            wipe_slot(s);
        requests_queued = 0;
        requests_taken  = 0;
        fail_count      = 0;
        cycle_count     = 0;
        in_accepted     = 1'b0;
        out_accepted    = 1'b0;
        send_wait       = 0;
        recv_wait       = 0;
        send_calm       = 1'b0;
        recv_calm       = 1'b0;
        sim_ms          = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed pass at the reset look-ahead of 10 ms.
        queue_add(32'd0, K_NONE, 16'hFFFF, 32'd5);                 // kind none rejected
        queue_add(32'd0, K_IDLE, 16'hFFFF, 32'hFFFF_FFFF);         // slot 0
        queue_add(32'd0, K_IDLE, 16'd0, 32'd0);                    // idle with code zero
        queue_add(32'd1000, K_ONCE, 16'd1, 32'd50);                // due 1050
        queue_add(32'd0, K_CYCLIC, 16'd2, 32'hFFFF_FFFF);          // longest period
        queue_add(32'hFFFF_FFF0, K_ONCE, 16'd3, 32'd32);           // due wraps to 0x10
        queue_add(32'd7, K_CYCLIC, 16'd0, 32'd0);                  // silent cyclic, period 0
        queue_add(32'd0, K_ONCE, 16'h8000, 32'd0);                 // due immediately
        queue_add(32'd0, K_IDLE, 16'd5, 32'd0);                    // fills the last slot
        queue_add(32'd0, K_IDLE, 16'd6, 32'd0);                    // table full
        queue_tick(32'd0);
        queue_tick(32'hFFFF_FFFF);                                 // everything due
        queue_kill(3'd7);
        queue_kill(3'd0);
        queue_kill(3'd5);
        queue_tick(32'd2000);
        queue_request(make_request(CMD_UNUSED, 32'hFFFF_FFFF, 2'd3, 16'hFFFF,
                                   32'hFFFF_FFFF, 3'd7));
        queue_kill(3'd2);
        queue_kill(3'd3);
        queue_kill(3'd4);
        queue_kill(3'd6);
        queue_tick(32'd5);                                         // idle pass, code zero only
        queue_add(32'd5, K_IDLE, 16'd7, 32'd0);
        queue_tick(32'd6);                                         // idle task dispatched
        wait_quiet();

        // Random phases, each under its own look-ahead.
        write_window(32'd0);
        queue_random_requests(PHASE_ITEMS);
        wait_quiet();

        write_window(32'hFFFF_FFFF);
        queue_random_requests(PHASE_ITEMS);
        wait_quiet();

        // run the time base across the 32-bit wrap
        sim_ms = 32'hFFFF_FF80;
        write_window($urandom_range(1, 60));
        queue_random_requests(PHASE_ITEMS);
        wait_quiet();

        write_window($urandom());
        queue_random_requests(PHASE_ITEMS);
        wait_quiet();

        write_window(32'd1);
        queue_random_requests(PHASE_ITEMS);
        wait_quiet();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
